@@ sv/cyl_pkg.sv @@
// Shared constants, types and the arctangent table for the Cartesian to
// cylindrical converter. No dependencies; every other file imports this.

package cyl_pkg;

	localparam int CORDIC_STAGES = 32;
	localparam int DATA_WIDTH    = 32;
	localparam int TABLE_LEN     = 48;
	localparam int ANG_GUARD     = 24;
	localparam int XY_GUARD      = DATA_WIDTH / 2;
	localparam int NSTAGE        = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;

	localparam int COORD_W   = 32;
	localparam int TDATA_W   = 3 * COORD_W;
	// Datapath word: sign, negated full-scale input, guard bits, CORDIC growth.
	localparam int XW        = COORD_W + XY_GUARD + 3;
	// Angle accumulator: 2^(32+ANG_GUARD) is a full turn, plus headroom.
	localparam int AW        = 32 + ANG_GUARD + 2;
	localparam int GW        = 40;
	localparam int RHO_SHIFT = 40 + XY_GUARD;

	localparam logic [63:0] GAIN_BASE = 64'd667681663043;
	localparam logic [63:0] GAIN_FULL = (2 * NSTAGE < 64) ?
		GAIN_BASE + (((GAIN_BASE / 3) * 2) >> (2 * NSTAGE)) : GAIN_BASE;
	localparam logic [GW-1:0] GAIN = GAIN_FULL[GW-1:0];

	typedef logic signed [XW-1:0] xy_t;
	typedef logic signed [AW-1:0] ang_t;

	localparam ang_t ANG_PI = ang_t'(1) << (31 + ANG_GUARD);

	typedef struct packed {
		logic signed [COORD_W-1:0] z_coord;
		logic signed [COORD_W-1:0] y_coord;
		logic signed [COORD_W-1:0] x_coord;
	} cyl_in_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] z_out;
		logic [COORD_W-1:0]        rho_radius;
		logic [COORD_W-1:0]        phi_angle;
	} cyl_out_t;

	// Vector state carried down the rotation stages.
	typedef struct packed {
		logic               zero;
		xy_t                x;
		xy_t                y;
		ang_t               acc;
		logic [COORD_W-1:0] z;
	} cyl_vec_t;

	typedef logic [TABLE_LEN-1:0][AW-1:0] atan_rom_t;

	// Restoring division, used only while the table is elaborated.
	function automatic logic [63:0] udiv64(input logic [63:0] a, input logic [63:0] b);
		logic [64:0] rem;
		logic [63:0] q;
		int j;
		rem = '0;
		q = '0;
		for (j = 63; j >= 0; j--) begin
			rem = {rem[63:0], a[j]};
			if (rem >= {1'b0, b}) begin
				rem = rem - {1'b0, b};
				q[j] = 1'b1;
			end
		end
		return q;
	endfunction

	// atan(1/n) in Q62 by the alternating series.
	function automatic logic [63:0] atan_inv_q62(input logic [63:0] n);
		logic [63:0] p;
		logic [63:0] sum;
		logic [63:0] term;
		int k;
		p = udiv64(64'd1 << 62, n);
		sum = '0;
		for (k = 0; k < 200; k++) begin
			if (p != 64'd0) begin
				term = udiv64(p, 64'(2 * k + 1));
				if (k[0])
					sum = sum - term;
				else
					sum = sum + term;
				p = udiv64(udiv64(p, n), n);
			end
		end
		return sum;
	endfunction

	// round(a * 2^(29+ANG_GUARD) / b) by long division.
	function automatic logic [63:0] ratio_round(input logic [63:0] a, input logic [63:0] b);
		logic [63:0] r;
		logic [63:0] q;
		int j;
		r = a;
		q = '0;
		for (j = 0; j <= 29 + ANG_GUARD; j++) begin
			r = r << 1;
			q = q << 1;
			if (r >= b) begin
				r = r - b;
				q[0] = 1'b1;
			end
		end
		return (q + 64'd1) >> 1;
	endfunction

	function automatic atan_rom_t build_atan_rom();
		atan_rom_t rom;
		logic [63:0] qpi;
		logic [63:0] ent;
		int i;
		qpi = (atan_inv_q62(64'd5) << 2) - atan_inv_q62(64'd239);
		ent = 64'd1 << (29 + ANG_GUARD);
		rom[0] = ent[AW-1:0];
		for (i = 1; i < TABLE_LEN; i++) begin
			ent = ratio_round(atan_inv_q62(64'd1 << i), qpi);
			rom[i] = ent[AW-1:0];
		end
		return rom;
	endfunction

	localparam atan_rom_t ATAN_ROM = build_atan_rom();

endpackage

@@ sv/cyl_pre.sv @@
// Input stage of the converter: origin detection, fold into the right
// half-plane and scaling to the datapath format. Depends on cyl_pkg.

module cyl_pre (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_valid,
	input  cyl_pkg::cyl_in_t in_data,
	output logic             out_valid,
	output cyl_pkg::cyl_vec_t out_vec
);
	import cyl_pkg::*;

	cyl_vec_t nxt;
	xy_t      xe;
	xy_t      ye;
	logic     valid_s1;
	cyl_vec_t vec_s1;

	always_comb begin
		xe = XW'(in_data.x_coord);
		ye = XW'(in_data.y_coord);
		nxt.acc = '0;
		// A point left of the y axis is mirrored through the origin; the
		// half turn is put back through the angle accumulator.
		if (in_data.x_coord[COORD_W-1]) begin
			xe = -xe;
			ye = -ye;
			nxt.acc = ANG_PI;
		end
		nxt.zero = (in_data.x_coord == '0) && (in_data.y_coord == '0);
		nxt.x = xe <<< XY_GUARD;
		nxt.y = ye <<< XY_GUARD;
		nxt.z = in_data.z_coord;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (en)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (en)
			vec_s1 <= nxt;
	end

	assign out_valid = valid_s1;
	assign out_vec   = vec_s1;

endmodule

@@ sv/cyl_cordic.sv @@
// Unrolled CORDIC vectoring chain, one registered micro-rotation per stage.
// Depends on cyl_pkg for widths and the arctangent table.

module cyl_cordic (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  cyl_pkg::cyl_vec_t in_vec,
	output logic              out_valid,
	output cyl_pkg::cyl_vec_t out_vec
);
	import cyl_pkg::*;

	logic     valid_s [NSTAGE+1];
	cyl_vec_t vec_s   [NSTAGE+1];

	assign valid_s[0] = in_valid;
	assign vec_s[0]   = in_vec;

	for (genvar i = 0; i < NSTAGE; i++) begin : g_stage
		xy_t      xc;
		xy_t      yc;
		cyl_vec_t nxt;

		always_comb begin
			xc = vec_s[i].x;
			yc = vec_s[i].y;
			nxt = vec_s[i];
			// A residual y of zero rotates clockwise, like a positive one.
			if (!yc[XW-1]) begin
				nxt.x = xc + (yc >>> i);
				nxt.y = yc - (xc >>> i);
				nxt.acc = vec_s[i].acc + ang_t'(ATAN_ROM[i]);
			end else begin
				nxt.x = xc - (yc >>> i);
				nxt.y = yc + (xc >>> i);
				nxt.acc = vec_s[i].acc - ang_t'(ATAN_ROM[i]);
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				valid_s[i+1] <= 1'b0;
			else if (en)
				valid_s[i+1] <= valid_s[i];
		end

		always_ff @(posedge clk) begin
			if (en)
				vec_s[i+1] <= nxt;
		end
	end

	assign out_valid = valid_s[NSTAGE];
	assign out_vec   = vec_s[NSTAGE];

endmodule

@@ sv/cyl_gain.sv @@
// Gain compensation and result formatting: the radius is multiplied by the
// inverse CORDIC gain in partial products over three stages. Uses cyl_pkg.

module cyl_gain (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  cyl_pkg::cyl_vec_t in_vec,
	output logic              out_valid,
	output cyl_pkg::cyl_out_t out_data
);
	import cyl_pkg::*;

	localparam int XU = XW - 1;
	localparam int XL = XU / 2;
	localparam int XH = XU - XL;
	localparam int GL = GW / 2;
	localparam int GH = GW - GL;
	localparam int PW = XU + GW + 1;
	localparam logic [PW-1:0] RND = PW'(1) << (RHO_SHIFT - 1);
	localparam logic [GL-1:0] G_LO = GAIN[GL-1:0];
	localparam logic [GH-1:0] G_HI = GAIN[GW-1:GL];

	logic [XU-1:0]    x_u;
	logic [AW-1:0]    phi_sum;

	logic             valid_s1;
	logic             valid_s2;
	logic             valid_s3;
	logic [XL+GL-1:0] p_ll_s1;
	logic [XL+GH-1:0] p_lh_s1;
	logic [XH+GL-1:0] p_hl_s1;
	logic [XH+GH-1:0] p_hh_s1;
	logic [COORD_W-1:0] phi_s1;
	logic [COORD_W-1:0] z_s1;
	logic [PW-1:0]    sum_a_s2;
	logic [PW-1:0]    sum_b_s2;
	logic [COORD_W-1:0] phi_s2;
	logic [COORD_W-1:0] z_s2;
	cyl_out_t         res_s3;

	logic [PW-1:0]    total;

	// The rotated x is never negative, so its magnitude bits are used as is.
	assign x_u     = in_vec.x[XU-1:0];
	assign phi_sum = in_vec.acc + (ang_t'(1) << (ANG_GUARD - 1));
	assign total   = sum_a_s2 + sum_b_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p_ll_s1 <= x_u[XL-1:0] * G_LO;
			p_lh_s1 <= x_u[XL-1:0] * G_HI;
			p_hl_s1 <= x_u[XU-1:XL] * G_LO;
			p_hh_s1 <= x_u[XU-1:XL] * G_HI;
			phi_s1  <= in_vec.zero ? '0 : phi_sum[ANG_GUARD+COORD_W-1:ANG_GUARD];
			z_s1    <= in_vec.z;

			sum_a_s2 <= PW'(p_ll_s1) + (PW'(p_lh_s1) << GL) + RND;
			sum_b_s2 <= (PW'(p_hl_s1) << XL) + (PW'(p_hh_s1) << (XL + GL));
			phi_s2   <= phi_s1;
			z_s2     <= z_s1;

			res_s3.phi_angle  <= phi_s2;
			res_s3.rho_radius <= (|total[PW-1:RHO_SHIFT+COORD_W]) ? '1 :
				total[RHO_SHIFT+COORD_W-1:RHO_SHIFT];
			res_s3.z_out      <= z_s2;
		end
	end

	assign out_valid = valid_s3;
	assign out_data  = res_s3;

endmodule

@@ sv/cartesian_to_cylindrical.sv @@
// Cartesian to cylindrical converter, top level with the output skid stage.
// Instantiates cyl_pre, cyl_cordic and cyl_gain; uses cyl_pkg.
//
// Usage: each request on the s_ side carries one point x, y, z in signed
// Q16.16. The m_ side returns one result per point, in order: the azimuth
// as a binary angle (2^32 is a full turn, range [0, 2pi)), the radius in
// unsigned Q16.16 and z unchanged. The origin gives angle 0 and radius 0.
// The pipeline takes one point every cycle while the receiver keeps up. A
// point accepted on the s_ side passes through one input stage, 32 CORDIC
// stages, three gain stages and the output register before it shows on
// m_tvalid. The depth is set by the number of CORDIC micro-rotations.
// Reset clears every valid bit, so the block comes up empty and ready.
// When the receiver stalls, the output holds its result and one more
// result is caught in a skid register; only then does s_tready drop, and
// the whole pipeline freezes until the receiver takes a result again.

module cartesian_to_cylindrical (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	// x_coord [31:0], y_coord [63:32], z_coord [95:64]
	input  logic [cyl_pkg::TDATA_W-1:0] s_tdata,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	// phi_angle [31:0], rho_radius [63:32], z_out [95:64]
	output logic [cyl_pkg::TDATA_W-1:0] m_tdata
);
	import cyl_pkg::*;

	logic     en;
	logic     pre_valid;
	cyl_vec_t pre_vec;
	logic     rot_valid;
	cyl_vec_t rot_vec;
	logic     end_valid;
	cyl_out_t end_data;

	logic     out_valid_q;
	logic     skid_valid_q;
	cyl_out_t out_q;
	cyl_out_t skid_q;

	// The pipeline runs whenever the skid register is free.
	assign en       = !skid_valid_q;
	assign s_tready = en;

	cyl_pre u_pre (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (s_tvalid),
		.in_data   (cyl_in_t'(s_tdata)),
		.out_valid (pre_valid),
		.out_vec   (pre_vec)
	);

	cyl_cordic u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (pre_valid),
		.in_vec    (pre_vec),
		.out_valid (rot_valid),
		.out_vec   (rot_vec)
	);

	cyl_gain u_gain (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (rot_valid),
		.in_vec    (rot_vec),
		.out_valid (end_valid),
		.out_data  (end_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (en) begin
			if (!out_valid_q || m_tready)
				out_valid_q <= end_valid;
			else if (end_valid)
				skid_valid_q <= 1'b1;
		end else if (m_tready) begin
			skid_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (!out_valid_q || m_tready)
				out_q <= end_data;
			else
				skid_q <= end_data;
		end else if (m_tready) begin
			out_q <= skid_q;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;

endmodule

@@ sv/cyl_checker.sv @@
// Port-level checks for the Cartesian to cylindrical converter, bound to
// the top level. Uses cyl_pkg for the data width.

module cyl_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        s_tready,
	input logic                        m_tvalid,
	input logic                        m_tready,
	input logic [cyl_pkg::TDATA_W-1:0] m_tdata
);
	import cyl_pkg::*;

	// A stalled result stays put until it is taken.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed or vanished while stalled");

	a_fall: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(m_tvalid) |-> $past(m_tready))
		else $error("result dropped without being taken");

	// Input back-pressure only follows a stalled output.
	a_bp_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> $past(m_tvalid && !m_tready))
		else $error("input stalled without an output stall");

	// A receiver that takes results never leaves the input blocked.
	a_bp_clear: assert property (@(posedge clk) disable iff (!arst_n)
		m_tready |=> s_tready)
		else $error("input still stalled after the output drained");

endmodule

bind cartesian_to_cylindrical cyl_checker u_cyl_checker (.*);
